### hdl/mft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg
// Shared types and constants of the MAC forwarding table: operation codes,
// field widths, the reset value of the aging limit and the result record.
// ----------------------------------------------------------------------------
package mft_pkg;

  localparam int MAC_W     = 48;
  localparam int PORT_ID_W = 8;
  localparam int TIME_W    = 32;

  // Aging limit after reset, in seconds.
  localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd300;

  // Table operations.
  typedef enum logic [1:0] {
    OP_LEARN   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_RELAY   = 2'd2,
    OP_DUMP    = 2'd3
  } op_t;

  // One result transaction as handed from the scan controller to the output.
  typedef struct packed {
    logic                 found;
    logic [MAC_W-1:0]     entry_mac;
    logic [PORT_ID_W-1:0] entry_port;
    logic                 entry_active;
    logic [TIME_W-1:0]    entry_time;
    logic                 relay;
    logic                 last;
  } mft_res_t;

endpackage
`default_nettype wire

### hdl/mft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module mft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hdl/mft_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_ctrl
// Scan sequencer of the forwarding table. It walks the entry RAM one entry
// per cycle while no result is held, keeps the per-entry valid bits, ages
// entries during resolve, selects the learn target and produces result transactions.
// ----------------------------------------------------------------------------
module mft_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int PORT_BITS   = 8,
  parameter int ENTRY_W     = 89
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Item start and fields.
  input  wire logic                              start,
  input  wire logic [1:0]                        opcode,
  input  wire logic [mft_pkg::MAC_W-1:0]         mac,
  input  wire logic [mft_pkg::PORT_ID_W-1:0]     port_id,
  input  wire logic                              port_active,
  input  wire logic [mft_pkg::TIME_W-1:0]        now,
  input  wire logic [mft_pkg::TIME_W-1:0]        max_age,
  output logic                                   busy,
  // Entry RAM.
  output logic                                   ram_wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]         ram_wr_addr,
  output logic [ENTRY_W-1:0]                     ram_wr_data,
  output logic                                   ram_rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]         ram_rd_addr,
  input  wire logic [ENTRY_W-1:0]                ram_rd_data,
  // Result hand-off.
  input  wire logic                              out_free,
  output logic                                   res_load,
  output mft_pkg::mft_res_t                      res
);

  import mft_pkg::*;

  localparam int IW     = $clog2(TABLE_DEPTH);
  localparam int CW     = IW + 1;
  localparam int PORT_W = (PORT_BITS < PORT_ID_W) ? PORT_BITS : PORT_ID_W;

  // Entry layout in RAM: {mac, port, active, time}.
  localparam int TIME_LO = 0;
  localparam int ACT_BIT = TIME_W;
  localparam int PORT_LO = TIME_W + 1;
  localparam int MAC_LO  = TIME_W + 1 + PORT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [TABLE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]            issue_r, issue_nxt;
  logic                     ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]            ev_idx_r, ev_idx_nxt;
  logic                     found_r, found_nxt;
  logic [IW-1:0]            tgt_r, tgt_nxt;
  logic [TIME_W-1:0]        oldest_r, oldest_nxt;
  logic [IW-1:0]            oldest_idx_r, oldest_idx_nxt;
  logic                     emitted_r, emitted_nxt;
  op_t                      op_r, op_nxt;
  logic [MAC_W-1:0]         mac_r, mac_nxt;
  logic [PORT_W-1:0]        port_r, port_nxt;
  logic                     active_r, active_nxt;
  logic [TIME_W-1:0]        now_r, now_nxt;

  // Fields of the entry under evaluation.
  logic [MAC_W-1:0]  rd_mac;
  logic [PORT_W-1:0] rd_port;
  logic              rd_up;
  logic [TIME_W-1:0] rd_time;
  logic [TIME_W-1:0] age;
  logic              valid_e;
  logic              match;
  logic              aged;
  logic              res_hit;
  logic              relay_hit;
  logic              last_idx;
  logic              above;
  logic              emit;
  logic              hold;
  logic [IW-1:0]     wr_idx;
  mft_res_t          res_entry;

  assign rd_mac   = ram_rd_data[MAC_LO +: MAC_W];
  assign rd_port  = ram_rd_data[PORT_LO +: PORT_W];
  assign rd_up    = ram_rd_data[ACT_BIT];
  assign rd_time  = ram_rd_data[TIME_LO +: TIME_W];
  assign age      = now_r - rd_time;
  assign valid_e  = valid_r[ev_idx_r];
  assign match    = valid_e && (rd_mac == mac_r);
  assign aged     = valid_e && (now_r >= rd_time) && (age > max_age);
  assign res_hit  = match && !aged;
  assign relay_hit = match && (rd_port == port_r) && rd_up;
  assign last_idx = (ev_idx_r == IW'(TABLE_DEPTH - 1));
  assign wr_idx   = found_r ? tgt_r : oldest_idx_r;

  // Any valid entry above the one under evaluation decides the dump marker.
  always_comb begin
    above = 1'b0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (valid_r[j] && (IW'(j) > ev_idx_r)) begin
        above = 1'b1;
      end
    end
  end

  // Result record built from the entry under evaluation.
  always_comb begin
    res_entry              = '0;
    res_entry.found        = 1'b1;
    res_entry.entry_mac    = rd_mac;
    res_entry.entry_port   = PORT_ID_W'(rd_port);
    res_entry.entry_active = rd_up;
    res_entry.entry_time   = rd_time;
  end

  // Decide whether the evaluated entry produces a result, and build it.
  always_comb begin
    emit = 1'b0;
    res  = '0;
    unique case (op_r)
      OP_LEARN: begin
        emit = 1'b0;
      end
      OP_RESOLVE: begin
        emit = ev_vld_r && (res_hit || last_idx);
        if (res_hit) begin
          res = res_entry;
        end
        res.last = 1'b1;
      end
      OP_RELAY: begin
        emit = ev_vld_r && (relay_hit || last_idx);
        if (relay_hit) begin
          res       = res_entry;
          res.relay = 1'b1;
        end
        res.last = 1'b1;
      end
      OP_DUMP: begin
        emit = ev_vld_r && (valid_e || (last_idx && !emitted_r));
        if (valid_e) begin
          res      = res_entry;
          res.last = !above;
        end else begin
          res.last = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign hold     = (state_r == S_SCAN) && emit && !out_free;
  assign res_load = (state_r == S_SCAN) && emit && !hold;
  assign busy     = (state_r != S_IDLE);

  // RAM access.
  assign ram_rd_en   = (state_r == S_SCAN) && !hold && (issue_r < CW'(TABLE_DEPTH));
  assign ram_rd_addr = issue_r[IW-1:0];
  assign ram_wr_en   = (state_r == S_WRITE);
  assign ram_wr_addr = wr_idx;
  assign ram_wr_data = {mac_r, port_r, active_r, now_r};

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    issue_nxt      = issue_r;
    ev_vld_nxt     = ev_vld_r;
    ev_idx_nxt     = ev_idx_r;
    found_nxt      = found_r;
    tgt_nxt        = tgt_r;
    oldest_nxt     = oldest_r;
    oldest_idx_nxt = oldest_idx_r;
    emitted_nxt    = emitted_r;
    op_nxt         = op_r;
    mac_nxt        = mac_r;
    port_nxt       = port_r;
    active_nxt     = active_r;
    now_nxt        = now_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt      = S_SCAN;
          issue_nxt      = '0;
          ev_vld_nxt     = 1'b0;
          found_nxt      = 1'b0;
          oldest_nxt     = now;
          oldest_idx_nxt = '0;
          emitted_nxt    = 1'b0;
          op_nxt         = op_t'(opcode);
          mac_nxt        = mac;
          port_nxt       = port_id[PORT_W-1:0];
          active_nxt     = port_active;
          now_nxt        = now;
        end
      end
      S_SCAN: begin
        if (!hold) begin
          // Advance the read pipeline by one entry.
          ev_vld_nxt = ram_rd_en;
          ev_idx_nxt = ram_rd_addr;
          if (ram_rd_en) begin
            issue_nxt = issue_r + CW'(1);
          end
          if (ev_vld_r) begin
            unique case (op_r)
              OP_LEARN: begin
                // First matching entry wins; otherwise the strictly oldest.
                if (match && !found_r) begin
                  found_nxt = 1'b1;
                  tgt_nxt   = ev_idx_r;
                end
                if ((valid_e ? rd_time : '0) < oldest_r) begin
                  oldest_nxt     = valid_e ? rd_time : '0;
                  oldest_idx_nxt = ev_idx_r;
                end
                if (last_idx) begin
                  state_nxt  = S_WRITE;
                  ev_vld_nxt = 1'b0;
                end
              end
              OP_RESOLVE: begin
                if (aged) begin
                  valid_nxt[ev_idx_r] = 1'b0;
                end
              end
              OP_RELAY, OP_DUMP: begin
              end
              default: begin
              end
            endcase
            if (res_load) begin
              emitted_nxt = 1'b1;
              if (res.last) begin
                state_nxt  = S_IDLE;
                ev_vld_nxt = 1'b0;
              end
            end
          end
        end
      end
      S_WRITE: begin
        valid_nxt[wr_idx] = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registers of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      ev_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      ev_vld_r <= ev_vld_nxt;
    end
    issue_r      <= issue_nxt;
    ev_idx_r     <= ev_idx_nxt;
    found_r      <= found_nxt;
    tgt_r        <= tgt_nxt;
    oldest_r     <= oldest_nxt;
    oldest_idx_r <= oldest_idx_nxt;
    emitted_r    <= emitted_nxt;
    op_r         <= op_nxt;
    mac_r        <= mac_nxt;
    port_r       <= port_nxt;
    active_r     <= active_nxt;
    now_r        <= now_nxt;
  end

endmodule
`default_nettype wire

### hdl/mac_forwarding_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Each transaction walks the entry RAM at one entry per cycle (one RAM read port).
// Learn makes a full scan, then writes its entry in the write state.
// Resolve and relay check end at the first hit, or after the last entry.
// Dump ends after the last valid entry.
// A result stalled in the output register holds the scan.
// Reset clears all valid bits at once, with no clearing pass; max_age resets to 300.
// ----------------------------------------------------------------------------
// mac_forwarding_table_core
// MAC learning table with aging: learn, resolve, relay check and dump over a
// RAM of entries with per-entry valid bits and a registered result stage.
// ----------------------------------------------------------------------------
module mac_forwarding_table_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int PORT_BITS   = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration write.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mft_pkg::TIME_W-1:0]     cfg_max_age,
  // Input transactions.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [mft_pkg::MAC_W-1:0]      in_mac,
  input  wire logic [mft_pkg::PORT_ID_W-1:0]  in_port_id,
  input  wire logic                           in_port_active,
  input  wire logic [mft_pkg::TIME_W-1:0]     in_now,
  // Result transactions.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_found,
  output logic [mft_pkg::MAC_W-1:0]           out_entry_mac,
  output logic [mft_pkg::PORT_ID_W-1:0]       out_entry_port,
  output logic                                out_entry_active,
  output logic [mft_pkg::TIME_W-1:0]          out_entry_time,
  output logic                                out_relay,
  output logic                                out_last
);

  import mft_pkg::*;

  localparam int IW      = $clog2(TABLE_DEPTH);
  localparam int PORT_W  = (PORT_BITS < PORT_ID_W) ? PORT_BITS : PORT_ID_W;
  localparam int ENTRY_W = MAC_W + PORT_W + 1 + TIME_W;

  logic [TIME_W-1:0]  max_age_r;
  logic               busy;
  logic               start;
  logic               ram_wr_en;
  logic [IW-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               out_free;
  logic               res_load;
  mft_res_t           res;
  logic               out_valid_r;
  mft_res_t           res_r;

  // Aging limit register; the user must send writes only while the table is idle; cfg_ready does not check it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= MAX_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_age_r <= cfg_max_age;
    end
  end

  // One transaction at a time enters the scan controller.
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  mft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  mft_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PORT_BITS   (PORT_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .opcode      (in_opcode),
    .mac         (in_mac),
    .port_id     (in_port_id),
    .port_active (in_port_active),
    .now         (in_now),
    .max_age     (max_age_r),
    .busy        (busy),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  // Output register: takes a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = res_r.found;
  assign out_entry_mac    = res_r.entry_mac;
  assign out_entry_port   = res_r.entry_port;
  assign out_entry_active = res_r.entry_active;
  assign out_entry_time   = res_r.entry_time;
  assign out_relay        = res_r.relay;
  assign out_last         = res_r.last;

endmodule
`default_nettype wire

### tb/sv/mac_forwarding_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_forwarding_table_core_test
// Self-checking bench for the MAC forwarding table. It keeps its own copy of
// the table and the aging limit, applies every learn, predicts the replies of
// every resolve, relay check and dump, and compares each result transaction field
// by field. Directed cases come first, then random traffic under several
// aging limits with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module mac_forwarding_table_core_test;
  import mft_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int PORT_BITS      = 8;
  localparam int SETTLE_CYCLES  = TABLE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAC_POOL_SIZE  = 20;
  localparam int MAX_PRINTED    = 40;

  localparam logic [MAC_W-1:0] MAC_ZERO      = '0;
  localparam logic [MAC_W-1:0] MAC_ONES      = '1;
  localparam logic [MAC_W-1:0] MAC_ODD_BITS  = 48'hAAAA_AAAA_AAAA;
  localparam logic [MAC_W-1:0] MAC_EVEN_BITS = 48'h5555_5555_5555;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [TIME_W-1:0]    cfg_max_age    = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode      = '0;
  logic [MAC_W-1:0]     in_mac         = '0;
  logic [PORT_ID_W-1:0] in_port_id     = '0;
  logic                 in_port_active = 1'b0;
  logic [TIME_W-1:0]    in_now         = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_found;
  logic [MAC_W-1:0]     out_entry_mac;
  logic [PORT_ID_W-1:0] out_entry_port;
  logic                 out_entry_active;
  logic [TIME_W-1:0]    out_entry_time;
  logic                 out_relay;
  logic                 out_last;

  // Private copy of the table and its aging limit.
  logic                 copy_valid [TABLE_DEPTH];
  logic [MAC_W-1:0]     copy_mac   [TABLE_DEPTH];
  logic [PORT_ID_W-1:0] copy_port  [TABLE_DEPTH];
  logic                 copy_up    [TABLE_DEPTH];
  logic [TIME_W-1:0]    copy_seen  [TABLE_DEPTH];
  logic [TIME_W-1:0]    copy_max_age = MAX_AGE_RESET;

  mft_res_t             replies_due [$];
  logic [MAC_W-1:0]     mac_pool [MAC_POOL_SIZE];
  logic [TIME_W-1:0]    clock_s = '0;
  int                   mismatches = 0;
  int                   quiet_cycles = 0;
  int                   stall_left = 0;
  int                   hold_results_for = 0;
  bit                   burst_mode = 1'b0;

  mac_forwarding_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_BITS  (PORT_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_age     (cfg_max_age),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_mac          (in_mac),
    .in_port_id      (in_port_id),
    .in_port_active  (in_port_active),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_entry_mac   (out_entry_mac),
    .out_entry_port  (out_entry_port),
    .out_entry_active(out_entry_active),
    .out_entry_time  (out_entry_time),
    .out_relay       (out_relay),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Queue one reply built from a table entry, or a miss with all entry fields zero when idx < 0.
  function automatic void push_reply(input int idx, input logic relay_bit,
                                     input logic last_bit);
    mft_res_t r;
    r = '0;
    if (idx >= 0) begin
      r.found        = 1'b1;
      r.entry_mac    = copy_mac[idx];
      r.entry_port   = copy_port[idx];
      r.entry_active = copy_up[idx];
      r.entry_time   = copy_seen[idx];
    end
    r.relay = relay_bit;
    r.last  = last_bit;
    replies_due.push_back(r);
  endfunction

  // Apply one accepted operation to the table copy and queue its replies.
  function automatic void table_copy_apply(input op_t op, input logic [MAC_W-1:0] mac,
                                           input logic [PORT_ID_W-1:0] port_in,
                                           input logic active,
                                           input logic [TIME_W-1:0] now);
    int                   hit;
    int                   oldest_idx;
    int                   last_idx;
    logic [TIME_W-1:0]    oldest;
    logic [PORT_ID_W-1:0] port;
    hit  = -1;
    port = port_in & PORT_ID_W'((1 << PORT_BITS) - 1);
    case (op)
      OP_LEARN: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (copy_valid[i] && copy_mac[i] == mac) begin
            hit = i;
            break;
          end
        end
        // No match: replace the first strictly oldest entry older than now, else entry 0.
        if (hit < 0) begin
          oldest     = now;
          oldest_idx = 0;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (copy_seen[i] < oldest) begin
              oldest     = copy_seen[i];
              oldest_idx = i;
            end
          end
          hit = oldest_idx;
        end
        copy_valid[hit] = 1'b1;
        copy_mac[hit]   = mac;
        copy_port[hit]  = port;
        copy_up[hit]    = active;
        copy_seen[hit]  = now;
      end
      OP_RESOLVE: begin
        // Age out visited entries up to and including the first match.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (copy_valid[i] && now >= copy_seen[i] && now - copy_seen[i] > copy_max_age) begin
            copy_valid[i] = 1'b0;
            copy_mac[i]   = '0;
            copy_port[i]  = '0;
            copy_up[i]    = 1'b0;
            copy_seen[i]  = '0;
          end
          if (copy_valid[i] && copy_mac[i] == mac) begin
            hit = i;
            break;
          end
        end
        push_reply(hit, 1'b0, 1'b1);
      end
      OP_RELAY: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (copy_valid[i] && copy_mac[i] == mac && copy_port[i] == port && copy_up[i]) begin
            hit = i;
            break;
          end
        end
        push_reply(hit, hit >= 0, 1'b1);
      end
      default: begin
        last_idx = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (copy_valid[i]) last_idx = i;
        if (last_idx < 0) push_reply(-1, 1'b0, 1'b1);
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (copy_valid[i]) push_reply(i, 1'b0, i == last_idx);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare every accepted result transaction with the oldest pending reply.
  always @(posedge clk) begin
    mft_res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result with no reply pending", 64'(out_entry_mac), 64'd0);
      end else begin
        want = replies_due.pop_front();
        check_field("found", out_found, want.found);
        check_field("entry_mac", out_entry_mac, want.entry_mac);
        check_field("entry_port", out_entry_port, want.entry_port);
        check_field("entry_active", out_entry_active, want.entry_active);
        check_field("entry_time", out_entry_time, want.entry_time);
        check_field("relay", out_relay, want.relay);
        check_field("last", out_last, want.last);
      end
    end
  end

  // Result side: random stall before each transaction, or a long hold on request.
  always @(posedge clk) begin
    if (hold_results_for > 0) begin
      stall_left       = hold_results_for;
      hold_results_for = 0;
    end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
      stall_left = burst_mode ? 0 : $urandom_range(0, 19);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // Watchdog on cycles in which no channel moves a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one operation after a random gap (none in burst mode) and hold it until it is taken.
  task automatic issue_op(input op_t op, input logic [MAC_W-1:0] mac,
                          input logic [PORT_ID_W-1:0] port, input logic active,
                          input logic [TIME_W-1:0] now);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_mac         <= mac;
    in_port_id     <= port;
    in_port_active <= active;
    in_now         <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    table_copy_apply(op, mac, port, active, now);
  endtask

  // Stop offering, wait for every pending reply, then let extra cycles pass.
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // The aging limit is written only once the table has gone quiet.
  task automatic set_max_age(input logic [TIME_W-1:0] value);
    wait_idle(SETTLE_CYCLES);
    cfg_valid   <= 1'b1;
    cfg_max_age <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid    <= 1'b0;
    copy_max_age  = value;
  endtask

  function automatic logic [MAC_W-1:0] pick_mac();
    if ($urandom_range(0, 99) < 75) return mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
    return MAC_W'({$urandom, $urandom});
  endfunction

  function automatic logic [PORT_ID_W-1:0] pick_port();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return PORT_ID_W'($urandom_range(0, 3));
    if (roll < 70) return '1;
    return PORT_ID_W'($urandom_range(0, 255));
  endfunction

  // Mostly forward time, with steps back, jumps and both extremes.
  function automatic logic [TIME_W-1:0] next_now();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 84) clock_s = clock_s + $urandom_range(0, 150);
    else if (roll < 92) clock_s = clock_s - $urandom_range(0, 400);
    else if (roll < 96) clock_s = $urandom;
    else if (roll < 98) clock_s = '0;
    else clock_s = '1;
    return clock_s;
  endfunction

  task automatic test_empty_table();
    issue_op(OP_DUMP, MAC_ZERO, '0, 1'b0, '0);
    issue_op(OP_RESOLVE, MAC_ZERO, '0, 1'b0, '0);
    issue_op(OP_RELAY, MAC_ZERO, '0, 1'b0, '0);
  endtask

  task automatic test_learn_and_lookup();
    // A learn at time zero lands in entry 0; a maximal time replaces it again.
    issue_op(OP_LEARN, MAC_ZERO, 8'd0, 1'b1, 32'd0);
    issue_op(OP_RELAY, MAC_ZERO, 8'd0, 1'b0, 32'd0);
    issue_op(OP_LEARN, MAC_ONES, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    issue_op(OP_RELAY, MAC_ONES, 8'hFF, 1'b1, 32'd5);
    issue_op(OP_RELAY, MAC_ONES, 8'hFE, 1'b1, 32'd5);
    // Inactive port never relays; a refresh makes it active.
    issue_op(OP_LEARN, MAC_ODD_BITS, 8'd7, 1'b0, 32'd10);
    issue_op(OP_RELAY, MAC_ODD_BITS, 8'd7, 1'b1, 32'd11);
    issue_op(OP_LEARN, MAC_ODD_BITS, 8'd7, 1'b1, 32'd20);
    issue_op(OP_RELAY, MAC_ODD_BITS, 8'd7, 1'b0, 32'd21);
    issue_op(OP_LEARN, MAC_EVEN_BITS, 8'd1, 1'b1, 32'd30);
    issue_op(OP_RESOLVE, MAC_EVEN_BITS, 8'd0, 1'b0, 32'd30);
    issue_op(OP_DUMP, MAC_ZERO, 8'd0, 1'b0, 32'd30);
  endtask

  task automatic test_aging();
    issue_op(OP_LEARN, mac_pool[4], 8'd3, 1'b1, 32'd1000);
    issue_op(OP_LEARN, mac_pool[5], 8'd2, 1'b0, 32'd1100);
    // Exactly the limit keeps the first entry; older ones on the way go.
    issue_op(OP_RESOLVE, mac_pool[5], 8'd0, 1'b0, 32'd1300);
    // Entries stamped in the future never age.
    issue_op(OP_RESOLVE, mac_pool[4], 8'd0, 1'b0, 32'd500);
    issue_op(OP_RESOLVE, mac_pool[5], 8'd0, 1'b0, 32'd1401);
    issue_op(OP_DUMP, MAC_ZERO, 8'd0, 1'b0, 32'd1401);
  endtask

  // Learn followed by lookups of the same address, mixed with loose operations.
  task automatic test_random_traffic(input int n_items, input logic [TIME_W-1:0] age);
    int                   done;
    int                   roll;
    int                   k;
    logic [MAC_W-1:0]     mac;
    logic [PORT_ID_W-1:0] port;
    done = 0;
    set_max_age(age);
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
      if (roll < 55) begin
        mac  = pick_mac();
        port = pick_port();
        k    = $urandom_range(1, 3);
        issue_op(OP_LEARN, mac, port, $urandom_range(0, 1), next_now());
        repeat (k) begin
          if ($urandom_range(0, 1))
            issue_op(OP_RELAY, mac, ($urandom_range(0, 3) == 0) ? pick_port() : port,
                     $urandom_range(0, 1), next_now());
          else
            issue_op(OP_RESOLVE, mac, pick_port(), $urandom_range(0, 1), next_now());
        end
        done += 1 + k;
      end else if (roll < 92) begin
        issue_op(op_t'($urandom_range(0, 2)), pick_mac(), pick_port(),
                 $urandom_range(0, 1), next_now());
        done++;
      end else if (roll < 97) begin
        issue_op(OP_DUMP, pick_mac(), pick_port(), $urandom_range(0, 1), next_now());
        done++;
      end else begin
        wait_idle(0);
      end
    end
    burst_mode = 1'b0;
  endtask

  // Hold the result side for a long stretch while lookups keep coming.
  task automatic test_backpressure();
    wait_idle(0);
    burst_mode       = 1'b1;
    hold_results_for = 400;
    repeat (30) begin
      issue_op($urandom_range(0, 1) ? OP_RELAY : OP_RESOLVE, pick_mac(), pick_port(),
               $urandom_range(0, 1), next_now());
    end
    burst_mode = 1'b0;
  endtask

  // Distinct addresses with rising times fill the table; the dump lists all.
  task automatic test_table_fill();
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] base;
    base = clock_s + 1000;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      mac       = MAC_W'({$urandom, $urandom});
      mac[5:0]  = k[5:0];
      clock_s   = base + k;
      issue_op(OP_LEARN, mac, pick_port(), $urandom_range(0, 1), clock_s);
    end
    issue_op(OP_DUMP, MAC_ZERO, '0, 1'b0, clock_s);
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      copy_valid[i] = 1'b0;
      copy_mac[i]   = '0;
      copy_port[i]  = '0;
      copy_up[i]    = 1'b0;
      copy_seen[i]  = '0;
    end
    mac_pool[0] = MAC_ZERO;
    mac_pool[1] = MAC_ONES;
    mac_pool[2] = MAC_ODD_BITS;
    mac_pool[3] = MAC_EVEN_BITS;
    for (int i = 4; i < MAC_POOL_SIZE; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_learn_and_lookup();
    test_aging();
    test_random_traffic(90, MAX_AGE_RESET);
    test_backpressure();
    test_random_traffic(50, '0);
    test_random_traffic(50, '1);
    test_table_fill();
    test_random_traffic(60, TIME_W'($urandom_range(1, 500)));

    wait_idle(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
